[sv/tfb_pkg.sv]
`default_nettype none

package tfb_pkg;

  localparam logic [7:0] HEAD_BYTE_RESET      = 8'hAA;
  localparam logic [7:0] TARGET_ADDRESS_RESET = 8'hFF;

  localparam int CfgIndexWidth = 8;

  localparam logic [CfgIndexWidth-1:0] CFG_HEAD_BYTE      = 8'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_TARGET_ADDRESS = 8'd1;

  typedef logic [2:0] phase_t;

  typedef struct packed {
    logic [7:0] frame_id;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_SUM,
    KIND_ADD
  } kind_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       last;
    logic       closes;
    logic [7:0] sum_nxt;
    logic [7:0] add_nxt;
  } emit_ctl_t;

endpackage

`default_nettype wire

[sv/tfb_emit.sv]
`default_nettype none

module tfb_emit (
  input  tfb_pkg::in_item_t  item,
  input  logic               in_frame,
  input  logic [7:0]         bytes_left,
  input  logic [7:0]         sum_check,
  input  logic [7:0]         add_check,
  input  tfb_pkg::phase_t    phase,
  input  logic [7:0]         head_byte,
  input  logic [7:0]         target_address,
  output tfb_pkg::emit_ctl_t ctl
);
  import tfb_pkg::*;

  logic       closes;
  phase_t     n_data;
  phase_t     count;
  kind_t      kind;
  logic [7:0] byte_val;
  logic [7:0] sum_base;
  logic [7:0] add_base;
  logic [7:0] sum_new;

  always_comb begin
    closes = in_frame ? (bytes_left == 8'd1) : (item.payload_length <= 8'd1);
    if (in_frame) begin
      n_data = 3'd1;
    end else if (item.payload_length == 8'd0) begin
      n_data = 3'd4;
    end else begin
      n_data = 3'd5;
    end
    count = n_data + (closes ? 3'd2 : 3'd0);

    if (phase < n_data) begin
      kind = KIND_BYTE;
    end else if (phase == n_data) begin
      kind = KIND_SUM;
    end else begin
      kind = KIND_ADD;
    end

    if (in_frame) begin
      byte_val = item.payload_byte;
    end else begin
      case (phase)
        3'd0:    byte_val = head_byte;
        3'd1:    byte_val = target_address;
        3'd2:    byte_val = item.frame_id;
        3'd3:    byte_val = item.payload_length;
        default: byte_val = item.payload_byte;
      endcase
    end

    // Both sums restart at the head byte of a new frame.
    if (!in_frame && phase == 3'd0) begin
      sum_base = 8'd0;
      add_base = 8'd0;
    end else begin
      sum_base = sum_check;
      add_base = add_check;
    end
    sum_new = sum_base + byte_val;

    ctl.closes    = closes;
    ctl.last      = (phase == count - 3'd1);
    ctl.frame_end = 1'b0;
    ctl.sum_nxt   = sum_check;
    ctl.add_nxt   = add_check;
    unique case (kind)
      KIND_BYTE: begin
        ctl.out_byte = byte_val;
        ctl.sum_nxt  = sum_new;
        ctl.add_nxt  = add_base + sum_new;
      end
      KIND_SUM: begin
        ctl.out_byte = sum_check;
      end
      KIND_ADD: begin
        ctl.out_byte  = add_check;
        ctl.frame_end = 1'b1;
      end
      default: begin
        ctl.out_byte = add_check;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/telemetry_frame_builder.sv]
`default_nettype none

// Frames a stream of payload bytes. An item that arrives while no frame is open
// opens one and yields head byte, target address, frame id, length and its
// payload byte (none when its length is zero); each further item yields its
// payload byte. After the last payload byte the sum and add checks follow, the
// latter flagged by frame_end, and run_last marks the final byte each item
// causes. Output runs at one byte per cycle while out_stall is low, set by the
// single byte sequencer, so a mid-frame item yields one byte, a frame-opening
// item five (four when its length is zero), and a closing item two more.
module telemetry_frame_builder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  tfb_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tfb_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tfb_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [7:0]                           cfg_data
);
  import tfb_pkg::*;

  logic [7:0] head_r;
  logic [7:0] head_nxt;
  logic [7:0] target_r;
  logic [7:0] target_nxt;

  in_item_t   item_r;
  logic       item_valid_r;
  logic       item_valid_nxt;
  logic       in_frame_r;
  logic       in_frame_nxt;
  logic [7:0] bytes_left_r;
  logic [7:0] bytes_left_nxt;
  logic [7:0] sum_r;
  logic [7:0] sum_nxt;
  logic [7:0] add_r;
  logic [7:0] add_nxt;
  phase_t     phase_r;
  phase_t     phase_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_data_r;

  emit_ctl_t  ctl;
  logic       out_free;
  logic       emit_en;
  logic       done;
  logic       accept;

  tfb_emit u_emit (
    .item           (item_r),
    .in_frame       (in_frame_r),
    .bytes_left     (bytes_left_r),
    .sum_check      (sum_r),
    .add_check      (add_r),
    .phase          (phase_r),
    .head_byte      (head_r),
    .target_address (target_r),
    .ctl            (ctl)
  );

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_en   = item_valid_r && out_free;
  assign done      = emit_en && ctl.last;
  assign in_stall  = item_valid_r && !done;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    head_nxt   = head_r;
    target_nxt = target_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEAD_BYTE:      head_nxt   = cfg_data;
        CFG_TARGET_ADDRESS: target_nxt = cfg_data;
        default: begin
        end
      endcase
    end

    item_valid_nxt = accept || (item_valid_r && !done);
    in_frame_nxt   = in_frame_r;
    bytes_left_nxt = bytes_left_r;
    sum_nxt        = sum_r;
    add_nxt        = add_r;
    phase_nxt      = phase_r;
    if (emit_en) begin
      sum_nxt = ctl.sum_nxt;
      add_nxt = ctl.add_nxt;
      if (ctl.last) begin
        phase_nxt    = 3'd0;
        in_frame_nxt = !ctl.closes;
        if (ctl.closes) begin
          bytes_left_nxt = 8'd0;
        end else if (in_frame_r) begin
          bytes_left_nxt = bytes_left_r - 8'd1;
        end else begin
          bytes_left_nxt = item_r.payload_length - 8'd1;
        end
      end else begin
        phase_nxt = phase_r + 3'd1;
      end
    end

    out_valid_nxt = out_free ? emit_en : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= HEAD_BYTE_RESET;
      target_r     <= TARGET_ADDRESS_RESET;
      item_valid_r <= 1'b0;
      in_frame_r   <= 1'b0;
      bytes_left_r <= 8'd0;
      sum_r        <= 8'd0;
      add_r        <= 8'd0;
      phase_r      <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      target_r     <= target_nxt;
      item_valid_r <= item_valid_nxt;
      in_frame_r   <= in_frame_nxt;
      bytes_left_r <= bytes_left_nxt;
      sum_r        <= sum_nxt;
      add_r        <= add_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (out_free) begin
      out_data_r.out_byte  <= ctl.out_byte;
      out_data_r.frame_end <= ctl.frame_end;
      out_data_r.run_last  <= ctl.last;
    end
  end

endmodule

`default_nettype wire
